>>> hdl/plti_pkg.sv
package plti_pkg;

  localparam int POINTS = 64;
  localparam int ADDR_W = $clog2(POINTS);
  localparam int CNT_W = $clog2(POINTS + 1);

  localparam int IDX_W = 6;
  localparam int TIME_W = 32;
  localparam int LOAD_W = 32;
  localparam int STAT_W = 3;
  localparam int TOL_W = 16;
  localparam int PC_W = 7;

  localparam int IDX_LO = 0;
  localparam int BT_LO = IDX_LO + IDX_W;
  localparam int BL_LO = BT_LO + TIME_W;
  localparam int QT_LO = BL_LO + LOAD_W;
  localparam int IN_BITS = QT_LO + TIME_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam int FRAC_W = 31;
  localparam int DIV_CNT_W = $clog2(FRAC_W);

  typedef enum logic [STAT_W-1:0] {
    ST_EXACT  = 3'd0,
    ST_INTERP = 3'd1,
    ST_BELOW  = 3'd2,
    ST_ABOVE  = 3'd3,
    ST_WRITE  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_COUNT = 1'b0,
    CFG_MATCH_TOL   = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_LA1,
    S_LA2,
    S_LA3,
    S_DIV,
    S_MUL,
    S_FIN,
    S_OUT
  } state_t;

endpackage

>>> hdl/piecewise_linear_table_interp_core.sv
// write item: no scan, straight to S_OUT; query item: table scan, one entry per cycle
// n = point count clamped to 2..64; an exact hit at slot k ends the scan at that slot,
// clamp and interpolation scan all n slots; interpolation adds a restoring divide + multiply
// one item at a time; the next item can be taken the cycle after its result is registered,
// even while that result still waits in the output register
// sync reset clears control and presets config; table contents are undefined until written
module piecewise_linear_table_interp_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [plti_pkg::IN_DATA_W-1:0]   s_tdata,   // entry_index, bp_time, bp_load, query_time
  input  logic                             s_tuser,   // req_type
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [plti_pkg::LOAD_W-1:0]      m_tdata,   // load_value
  output logic [plti_pkg::STAT_W-1:0]      m_tuser,   // status
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [plti_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [plti_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import plti_pkg::*;

  logic [TIME_W-1:0] time_mem [POINTS];
  logic [LOAD_W-1:0] load_mem [POINTS];

  state_t state, state_next;

  logic [PC_W-1:0]   point_count;
  logic [TOL_W-1:0]  match_tol;
  logic [CNT_W-1:0]  n_used;

  logic [TIME_W-1:0] q;
  logic [TIME_W-1:0] time_rd;
  logic [LOAD_W-1:0] load_rd;
  logic [ADDR_W-1:0] t_addr;
  logic [ADDR_W-1:0] ld_addr;
  logic [ADDR_W-1:0] scan_i;
  logic [TIME_W-1:0] t_prev;
  logic [TIME_W-1:0] t_first;
  logic              br_found;
  logic [ADDR_W-1:0] br_idx;
  logic              interp;
  status_t           res_status;
  logic [LOAD_W-1:0] res_load;
  logic [LOAD_W-1:0] l0;
  logic              neg;
  logic [LOAD_W-1:0] mag;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] den;
  logic [FRAC_W-1:0] quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [LOAD_W+FRAC_W-1:0] prod;

  logic              in_acc;
  logic              wr_en;
  logic              out_free;
  logic [TIME_W-1:0] diff;
  logic              match;
  logic              br_now;
  logic              scan_last;
  logic [LOAD_W:0]   dl;
  logic [TIME_W:0]   sh;
  logic              ge;
  logic [LOAD_W+FRAC_W:0] rnd;
  logic [LOAD_W-1:0] off;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= PC_W'(2);
      match_tol   <= TOL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POINT_COUNT: point_count <= cfg_data[PC_W-1:0];
        CFG_MATCH_TOL:   match_tol   <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(point_count) < 2) begin
      n_used = CNT_W'(2);
    end else if (int'(point_count) > POINTS) begin
      n_used = CNT_W'(POINTS);
    end else begin
      n_used = CNT_W'(point_count);
    end
  end

  // handshake and scan compare
  assign in_acc   = s_tvalid && s_tready;
  assign wr_en    = in_acc && !s_tuser && (int'(s_tdata[IDX_LO +: IDX_W]) < POINTS);
  assign out_free = !m_tvalid || m_tready;

  assign diff      = (q > time_rd) ? q - time_rd : time_rd - q;
  assign match     = diff <= TIME_W'(match_tol);
  assign br_now    = (scan_i != '0) && !br_found && (t_prev < q) && (q < time_rd);
  assign scan_last = CNT_W'(scan_i) == n_used - CNT_W'(1);

  assign dl  = {load_rd[LOAD_W-1], load_rd} - {l0[LOAD_W-1], l0};
  assign sh  = {rem, 1'b0};
  assign ge  = sh >= {1'b0, den};
  assign rnd = {1'b0, prod} + ((LOAD_W+FRAC_W+1)'(1) << (FRAC_W - 1));
  assign off = rnd[FRAC_W +: LOAD_W];

  // memories
  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[ADDR_W'(s_tdata[IDX_LO +: IDX_W])] <= s_tdata[BT_LO +: TIME_W];
      load_mem[ADDR_W'(s_tdata[IDX_LO +: IDX_W])] <= s_tdata[BL_LO +: LOAD_W];
    end
    time_rd <= time_mem[t_addr];
    load_rd <= load_mem[ld_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = s_tuser ? S_SCAN : S_OUT;
        end
      end
      S_SCAN: begin
        if (match || scan_last) begin
          state_next = S_LA1;
        end
      end
      S_LA1: state_next = S_LA2;
      S_LA2: state_next = interp ? S_LA3 : S_OUT;
      S_LA3: state_next = S_DIV;
      S_DIV: begin
        if (div_cnt == DIV_CNT_W'(FRAC_W - 1)) begin
          state_next = S_MUL;
        end
      end
      S_MUL: state_next = S_FIN;
      S_FIN: state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready = 1'b0;
    t_addr   = '0;
    case (state)
      S_IDLE: s_tready = 1'b1;
      S_SCAN: t_addr = scan_i + ADDR_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        q        <= s_tdata[QT_LO +: TIME_W];
        scan_i   <= '0;
        br_found <= 1'b0;
        interp   <= 1'b0;
        div_cnt  <= '0;
        res_load <= '0;
        res_status <= ST_WRITE;
      end
      S_SCAN: begin
        scan_i <= scan_i + ADDR_W'(1);
        t_prev <= time_rd;
        if (scan_i == '0) begin
          t_first <= time_rd;
        end
        if (br_now) begin
          br_found <= 1'b1;
          br_idx   <= scan_i - ADDR_W'(1);
          rem      <= q - t_prev;
          den      <= time_rd - t_prev;
        end
        if (match) begin
          ld_addr    <= scan_i;
          res_status <= ST_EXACT;
        end else if (scan_last) begin
          if (br_now || br_found) begin
            ld_addr    <= br_now ? scan_i - ADDR_W'(1) : br_idx;
            interp     <= 1'b1;
            res_status <= ST_INTERP;
          end else if (q < t_first) begin
            ld_addr    <= '0;
            res_status <= ST_BELOW;
          end else begin
            ld_addr    <= ADDR_W'(n_used - CNT_W'(1));
            res_status <= ST_ABOVE;
          end
        end
      end
      S_LA1: begin
        if (interp) begin
          ld_addr <= ld_addr + ADDR_W'(1);
        end
      end
      S_LA2: begin
        l0       <= load_rd;
        res_load <= load_rd;
      end
      S_LA3: begin
        neg <= dl[LOAD_W];
        mag <= dl[LOAD_W] ? LOAD_W'(-dl) : dl[LOAD_W-1:0];
      end
      S_DIV: begin
        rem     <= ge ? TIME_W'(sh - {1'b0, den}) : sh[TIME_W-1:0];
        quo     <= {quo[FRAC_W-2:0], ge};
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      S_MUL: begin
        prod <= (LOAD_W+FRAC_W)'(mag) * (LOAD_W+FRAC_W)'(quo);
      end
      S_FIN: begin
        res_load <= neg ? l0 - off : l0 + off;
      end
      S_OUT: begin
        if (out_free) begin
          m_tdata <= res_load;
          m_tuser <= res_status;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/plti_checker.sv
module plti_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [plti_pkg::LOAD_W-1:0]   m_tdata,
  input logic [plti_pkg::STAT_W-1:0]   m_tuser
);
  import plti_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output item changed while stalled");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_WRITE |-> m_tdata == '0)
    else $error("write acknowledge carries nonzero load");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in progress");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind piecewise_linear_table_interp_core plti_checker u_plti_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> test/piecewise_linear_table_interp_core_tb.sv
module piecewise_linear_table_interp_core_tb;
  import plti_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [LOAD_W-1:0] load;
    status_t           status;
  } load_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [LOAD_W-1:0]     m_tdata;
  logic [STAT_W-1:0]     m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit [TIME_W-1:0] time_tbl [POINTS];
  bit [LOAD_W-1:0] load_tbl [POINTS];
  bit [PC_W-1:0]   pc_reg = 7'd2;
  bit [TOL_W-1:0]  tol_reg = 16'd1;

  load_result_t expected_loads [$];
  load_result_t head;
  int           errors = 0;
  int           cycle_count = 0;
  int           burst_left = 0;
  int           gap_top = 0;
  int           stall_mode = 0;

  piecewise_linear_table_interp_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= (cycle_count % 37) >= 22;
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_loads.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual load %h status %0d",
                 $time, m_tdata, m_tuser);
        errors++;
      end else begin
        head = expected_loads.pop_front();
        if (m_tdata !== head.load) begin
          $display("%0t: load mismatch, expected %h actual %h", $time, head.load, m_tdata);
          errors++;
        end
        if (m_tuser !== head.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, head.status, m_tuser);
          errors++;
        end
      end
    end
  end

  function automatic int used_count();
    if (pc_reg < 2) return 2;
    if (pc_reg > POINTS) return POINTS;
    return int'(pc_reg);
  endfunction

  function automatic load_result_t predict_load(input bit req, input bit [IDX_W-1:0] idx,
                                                input bit [TIME_W-1:0] bt,
                                                input bit [LOAD_W-1:0] bl,
                                                input bit [TIME_W-1:0] q);
    load_result_t r;
    int           n;
    bit [31:0]    diff;
    bit [63:0]    num;
    bit [63:0]    den;
    bit [63:0]    frac;
    bit [63:0]    mag;
    bit [63:0]    off;
    longint       l0;
    longint       d;
    longint       res;
    r.load = '0;
    r.status = ST_WRITE;
    if (!req) begin
      time_tbl[idx] = bt;
      load_tbl[idx] = bl;
      return r;
    end
    n = used_count();
    for (int i = 0; i < n; i++) begin
      diff = (q > time_tbl[i]) ? q - time_tbl[i] : time_tbl[i] - q;
      if (diff <= tol_reg) begin
        r.load = load_tbl[i];
        r.status = ST_EXACT;
        return r;
      end
    end
    for (int i = 0; i + 1 < n; i++) begin
      if (time_tbl[i] < q && q < time_tbl[i+1]) begin
        num = {32'd0, q - time_tbl[i]} << 31;
        den = {32'd0, time_tbl[i+1] - time_tbl[i]};
        frac = num / den;
        l0 = longint'(signed'(load_tbl[i]));
        d = longint'(signed'(load_tbl[i+1])) - l0;
        mag = (d < 0) ? -d : d;
        off = (mag * frac + (64'd1 << 30)) >> 31;
        res = (d < 0) ? l0 - longint'(off) : l0 + longint'(off);
        r.load = res[31:0];
        r.status = ST_INTERP;
        return r;
      end
    end
    if (q < time_tbl[0]) begin
      r.load = load_tbl[0];
      r.status = ST_BELOW;
    end else begin
      r.load = load_tbl[n-1];
      r.status = ST_ABOVE;
    end
    return r;
  endfunction

  function automatic bit [LOAD_W-1:0] pick_load();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input bit req, input bit [IDX_W-1:0] idx,
                           input bit [TIME_W-1:0] bt, input bit [LOAD_W-1:0] bl,
                           input bit [TIME_W-1:0] q);
    logic [IN_DATA_W-1:0] word;
    int                   gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_top > 0) ? $urandom_range(0, gap_top) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    word = '0;
    word[IDX_LO +: IDX_W] = idx;
    word[BT_LO +: TIME_W] = bt;
    word[BL_LO +: LOAD_W] = bl;
    word[QT_LO +: TIME_W] = q;
    expected_loads.insert(expected_loads.size(), predict_load(req, idx, bt, bl, q));
    s_tvalid <= 1'b1;
    s_tdata <= word;
    s_tuser <= req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_query(input bit [TIME_W-1:0] q);
    send_item(1'b1, IDX_W'($urandom_range(0, 63)), $urandom, $urandom, q);
  endtask

  task automatic send_entry(input bit [IDX_W-1:0] idx, input bit [TIME_W-1:0] bt,
                            input bit [LOAD_W-1:0] bl);
    send_item(1'b0, idx, bt, bl, $urandom);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_loads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input cfg_reg_t reg_sel, input bit [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= reg_sel;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (reg_sel == CFG_POINT_COUNT) pc_reg = value[PC_W-1:0];
    else tol_reg = value[TOL_W-1:0];
  endtask

  // reset settings: two points, tolerance of one lsb
  task automatic test_match_and_clamp();
    gap_top = 0;
    stall_mode = 0;
    send_entry(0, 32'h0001_0000, 32'h8000_0000);
    send_entry(1, 32'hFFFF_0000, 32'h7FFF_FFFF);
    send_query(32'h0000_0000);
    send_query(32'h0001_0000);
    send_query(32'h0000_FFFF);
    send_query(32'h0001_0001);
    send_query(32'h0001_0002);
    send_query(32'h8000_0000);
    send_query(32'hFFFE_FFFE);
    send_query(32'hFFFF_FFFF);
    // falling segment
    send_entry(0, 32'h0001_0000, 32'h7FFF_FFFF);
    send_entry(1, 32'h0003_0000, 32'hFFFE_0000);
    send_query(32'h0002_8000);
    send_query(32'h0001_0003);
    // equal times never bracket
    send_entry(1, 32'h0001_0000, 32'h0000_1234);
    send_query(32'h0000_8000);
    send_query(32'h0002_0000);
    // descending table falls through to clamping
    send_entry(0, 32'h0000_0900, 32'h0000_0005);
    send_entry(1, 32'h0000_0100, 32'hFFFF_FFFB);
    send_query(32'h0000_0500);
    send_query(32'h0000_0050);
    send_query(32'h0000_0A00);
    wait_idle();
  endtask

  task automatic test_tolerance_edges();
    write_reg(CFG_MATCH_TOL, 16'h0000);
    write_reg(CFG_POINT_COUNT, 16'h0000);
    send_entry(0, 32'h0000_1000, 32'h0001_0000);
    send_entry(1, 32'h0000_3000, 32'hFFFF_0000);
    send_query(32'h0000_1000);
    send_query(32'h0000_1001);
    send_query(32'h0000_2FFF);
    write_reg(CFG_MATCH_TOL, 16'hFFFF);
    send_query(32'h0001_0FFF);
    send_query(32'h0000_0000);
    send_query(32'h0002_0000);
    wait_idle();
  endtask

  task automatic test_random_tables();
    bit [CFG_DATA_W-1:0] pc_val;
    bit [CFG_DATA_W-1:0] tol_val;
    bit [63:0]           acc;
    int unsigned         span;
    bit                  unsorted;
    bit [TIME_W-1:0]     t_new;
    bit [TIME_W-1:0]     q;
    int unsigned         delta;
    int                  n;
    int                  k;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin pc_val = 16'd2;    tol_val = 16'd1;    end
        1: begin pc_val = 16'd64;   tol_val = 16'd0;    end
        2: begin pc_val = 16'd64;   tol_val = 16'hFFFF; end
        3: begin pc_val = 16'd0;    tol_val = 16'd16;   end
        4: begin pc_val = 16'd127;  tol_val = 16'h0100; end
        5: begin pc_val = 16'hFF8A; tol_val = 16'h8000; end
        default: begin
          pc_val = CFG_DATA_W'($urandom_range(2, 64));
          tol_val = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
        end
      endcase
      write_reg(CFG_POINT_COUNT, pc_val);
      write_reg(CFG_MATCH_TOL, tol_val);
      gap_top = (ph == 0) ? 0 : $urandom_range(1, 12);
      stall_mode = ph % 4;

      case ($urandom_range(0, 3))
        0: span = 8;
        1: span = 32'h400;
        2: span = 32'h2_0000;
        default: span = 32'h400_0000;
      endcase
      unsorted = (ph != 0) && ($urandom_range(0, 4) == 0);
      acc = 64'($urandom_range(0, span));
      for (int s = 0; s < POINTS; s++) begin
        if (unsorted) begin
          t_new = $urandom;
        end else begin
          if ($urandom_range(0, 15) != 0) acc += 64'($urandom_range(1, span));
          if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
          t_new = acc[31:0];
        end
        send_entry(IDX_W'(s), t_new, pick_load());
      end

      repeat (140) begin
        n = used_count();
        if ($urandom_range(0, 5) == 0) begin
          k = $urandom_range(0, POINTS - 1);
          t_new = ($urandom_range(0, 7) == 0) ? $urandom : time_tbl[k];
          send_entry(IDX_W'(k), t_new, pick_load());
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2: begin
              k = $urandom_range(0, n - 1);
              delta = $urandom_range(0, tol_reg + 3);
              q = $urandom_range(0, 1) ? time_tbl[k] + delta : time_tbl[k] - delta;
            end
            3, 4, 5: begin
              k = $urandom_range(0, n - 2);
              if (time_tbl[k+1] > time_tbl[k])
                q = time_tbl[k] + $urandom_range(0, time_tbl[k+1] - time_tbl[k]);
              else
                q = time_tbl[k];
            end
            6: q = $urandom_range(0, time_tbl[0]);
            7: q = $urandom_range(time_tbl[n-1], 32'hFFFF_FFFF);
            8: q = $urandom;
            default: q = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
          endcase
          send_query(q);
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    test_match_and_clamp();
    test_tolerance_edges();
    test_random_tables();
    wait_idle();
    repeat (120) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
